[sv/gemm_pkg.sv]
// Shared types and constants of the integer matrix-multiply engine.
package gemm_pkg;

    // Number of multiply-accumulate lanes; a column n lives in lane n % LANES.
    localparam int LANES  = 16;
    localparam int LANE_W = 4;

    // Fixed field widths.
    localparam int ACT_W  = 8;
    localparam int IDX_W  = 8;
    localparam int WT_W   = 16;
    localparam int BIAS_W = 32;
    localparam int RES_W  = 16;
    // Unsigned 8-bit activation (made 9-bit signed) times signed 16-bit weight.
    localparam int PROD_W = 25;

    // Configuration port.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int ROWS_W     = 16;
    localparam int DEPTH_W    = 9;
    localparam int COLS_W     = 9;

    localparam logic [RES_W-1:0] RES_MAX = 16'hFFFF;

    // Input word actions.
    typedef enum logic [1:0] {
        ACT_WR_WEIGHT = 2'd0,
        ACT_WR_BIAS   = 2'd1,
        ACT_ELEMENT   = 2'd2,
        ACT_READ      = 2'd3
    } t_action;

    // Register index (byte address / 4).
    typedef enum logic [1:0] {
        REG_ROWS  = 2'd0,
        REG_DEPTH = 2'd1,
        REG_COLS  = 2'd2
    } t_reg_idx;

    // Per-lane control from the sequencer.
    typedef struct packed {
        logic wt_we;    // write one weight
        logic bias_we;  // write one bias
        logic rd_en;    // read all stores at the given group
        logic mac_en;   // the read belongs to an accumulate sweep
        logic col_use;  // this lane's column of the group is in use
        logic first_k;  // depth 0: restart from the bias
    } t_lane_ctl;

endpackage

[sv/gemm_in_if.sv]
// Input channel: one command word per handshake.
interface gemm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [7:0]         depth_index;
    logic [7:0]         column_index;
    logic signed [15:0] weight_value;
    logic signed [31:0] bias_value;
    logic [7:0]         act_value;

    modport source (
        output valid, action, depth_index, column_index, weight_value, bias_value,
               act_value,
        input  ready
    );
    modport sink (
        input  valid, action, depth_index, column_index, weight_value, bias_value,
               act_value,
        output ready
    );
endinterface

[sv/gemm_out_if.sv]
// Output channel: one result word per handshake.
interface gemm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_value;
    logic [7:0]  result_column;
    logic        last_of_matrix;

    modport source (
        output valid, result_value, result_column, last_of_matrix,
        input  ready
    );
    modport sink (
        input  valid, result_value, result_column, last_of_matrix,
        output ready
    );
endinterface

[sv/gemm_lane.sv]
// One multiply-accumulate lane: weight, bias and accumulator banks plus the MAC pipeline.
module gemm_lane
    import gemm_pkg::*;
#(
    parameter int   GROUPS    = 16,
    parameter int   WT_DEPTH  = 4096,
    parameter int   ACC_WIDTH = 40,
    localparam int  GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1,
    localparam int  WA_W      = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic [WA_W-1:0]          i_wt_addr,
    input  logic [GRP_W-1:0]         i_grp,
    input  logic signed [WT_W-1:0]   i_wt_data,
    input  logic signed [BIAS_W-1:0] i_bias_data,
    input  logic [ACT_W-1:0]         i_act,
    output logic [ACC_WIDTH-1:0]     o_acc
);

    // Storage banks of this lane.
    logic signed [WT_W-1:0]   wt_mem   [WT_DEPTH];
    logic signed [BIAS_W-1:0] bias_mem [GROUPS];
    logic [ACC_WIDTH-1:0]     acc_mem  [GROUPS];

    // Registered read data.
    logic signed [WT_W-1:0]   r_wt_rd;
    logic signed [BIAS_W-1:0] r_bias_rd;
    logic [ACC_WIDTH-1:0]     r_acc_rd;

    // Pipeline registers.
    logic                     r_p1_vld;
    logic                     r_p1_first;
    logic [GRP_W-1:0]         r_p1_grp;
    logic                     r_p2_we;
    logic [GRP_W-1:0]         r_p2_grp;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_WIDTH-1:0]     r_base;
    logic [ACC_WIDTH-1:0]     sum;

    // Weight bank: single port, write for loads, read during a sweep or a result read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wt_we) begin
            wt_mem[i_wt_addr] <= i_wt_data;
        end
        if (i_ctl.rd_en) begin
            r_wt_rd <= wt_mem[i_wt_addr];
        end
    end

    // Bias bank.
    always_ff @(posedge i_clk) begin
        if (i_ctl.bias_we) begin
            bias_mem[i_grp] <= i_bias_data;
        end
        if (i_ctl.rd_en) begin
            r_bias_rd <= bias_mem[i_grp];
        end
    end

    // Accumulator bank: read at the issue address, written back at the group carried through r_p1_grp and r_p2_grp.
    always_ff @(posedge i_clk) begin
        if (r_p2_we) begin
            acc_mem[r_p2_grp] <= sum;
        end
        if (i_ctl.rd_en) begin
            r_acc_rd <= acc_mem[i_grp];
        end
    end

    // Pipeline valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_we  <= 1'b0;
        end else begin
            r_p1_vld <= i_ctl.rd_en && i_ctl.mac_en && i_ctl.col_use;
            r_p2_we  <= r_p1_vld;
        end
    end

    // Stage one carries the group; stage two holds the product and the base value.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_p1_first <= i_ctl.first_k;
            r_p1_grp   <= i_grp;
        end
        r_p2_grp <= r_p1_grp;
        r_prod   <= $signed({1'b0, i_act}) * r_wt_rd;
        if (r_p1_first) begin
            r_base <= {{(ACC_WIDTH-BIAS_W){r_bias_rd[BIAS_W-1]}}, r_bias_rd};
        end else begin
            r_base <= r_acc_rd;
        end
    end

    // The sum wraps at the accumulator width.
    assign sum   = r_base + {{(ACC_WIDTH-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign o_acc = r_acc_rd;

endmodule

[sv/gemm_u8_i16_bias_sat_u16_unit.sv]
// Top level of the integer matrix-multiply engine: sequencer, registers and result stage.
//
//  channel  direction  handshake      carries
//  i_in     in         valid/ready    action, depth_index, column_index, weight_value,
//                                     bias_value, act_value
//  o_res    out        valid/ready    result_value, result_column, last_of_matrix
//  apb      in         psel/penable   rows_in_use, depth_in_use, columns_in_use
//
// A weight or bias write is done as the word is taken. An activation element sweeps the columns
// in use sixteen at a time through the lane memories, group by group in S_MAC and then S_DRAIN;
// no new word is taken until the sweep ends. A read loads the output register from S_RDOUT.
// Reset is synchronous; the stores hold no reset value and need no clearing pass.
// A result waits in the output register while the next word is taken; a second read
// stalls only until that register is free.
module gemm_u8_i16_bias_sat_u16_unit
    import gemm_pkg::*;
#(
    parameter int MAX_DEPTH   = 256,
    parameter int MAX_COLUMNS = 256,
    parameter int ACC_WIDTH   = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gemm_in_if.sink               i_in,
    gemm_out_if.source            o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int GROUPS   = (MAX_COLUMNS + LANES - 1) / LANES;
    localparam int GRP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int WT_DEPTH = MAX_DEPTH * GROUPS;
    localparam int WA_W     = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
    localparam int CE_W     = $clog2(MAX_COLUMNS + 1);
    localparam int DE_W     = $clog2(MAX_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_RDOUT
    } t_state;

    // Configuration registers.
    logic [ROWS_W-1:0]  r_cfg_rows;
    logic [DEPTH_W-1:0] r_cfg_depth;
    logic [COLS_W-1:0]  r_cfg_cols;

    // Sequencer and output registers.
    t_state             r_state;
    logic [GRP_W-1:0]   r_grp;
    logic [IDX_W-1:0]   r_k;
    logic [ACT_W-1:0]   r_act;
    logic               r_drain;
    logic [LANE_W-1:0]  r_lane;
    logic [IDX_W-1:0]   r_col;
    logic [ROWS_W-1:0]  r_row;
    logic               r_out_vld;
    logic [RES_W-1:0]   r_out_val;
    logic [IDX_W-1:0]   r_out_col;
    logic               r_out_last;

    // Derived values.
    logic [CE_W-1:0]      cols_eff;
    logic [DE_W-1:0]      depth_eff;
    logic [ROWS_W-1:0]    rows_eff;
    logic [GRP_W-1:0]     last_grp;
    t_action              act;
    logic                 in_acc;
    logic                 k_ok;
    logic                 n_ok;
    logic [LANE_W-1:0]    in_lane;
    logic [GRP_W-1:0]     in_grp;
    logic                 mac_issue;
    logic [WA_W-1:0]      wt_addr;
    logic [GRP_W-1:0]     grp_addr;
    logic [ACC_WIDTH-1:0] acc_sel;
    logic [RES_W-1:0]     clamped;
    logic                 col_last;
    logic                 row_wrap;
    logic                 cfg_wr;

    t_lane_ctl            lane_ctl [LANES];
    logic [ACC_WIDTH-1:0] lane_acc [LANES];

    // Register port: always ready, written on the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows  <= ROWS_W'(1);
            r_cfg_depth <= DEPTH_W'(256);
            r_cfg_cols  <= COLS_W'(256);
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_ROWS:  r_cfg_rows  <= pwdata[ROWS_W-1:0];
                REG_DEPTH: r_cfg_depth <= pwdata[DEPTH_W-1:0];
                REG_COLS:  r_cfg_cols  <= pwdata[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_ROWS:  prdata = CFG_DATA_W'(r_cfg_rows);
            REG_DEPTH: prdata = CFG_DATA_W'(r_cfg_depth);
            REG_COLS:  prdata = CFG_DATA_W'(r_cfg_cols);
            default:   prdata = '0;
        endcase
    end

    // Zero counts as one; values above the build limits are clipped.
    always_comb begin
        if (r_cfg_cols == '0) begin
            cols_eff = CE_W'(1);
        end else if (32'(r_cfg_cols) > MAX_COLUMNS) begin
            cols_eff = CE_W'(MAX_COLUMNS);
        end else begin
            cols_eff = CE_W'(r_cfg_cols);
        end
        if (r_cfg_depth == '0) begin
            depth_eff = DE_W'(1);
        end else if (32'(r_cfg_depth) > MAX_DEPTH) begin
            depth_eff = DE_W'(MAX_DEPTH);
        end else begin
            depth_eff = DE_W'(r_cfg_depth);
        end
        rows_eff = (r_cfg_rows == '0) ? ROWS_W'(1) : r_cfg_rows;
        last_grp = GRP_W'((32'(cols_eff) - 32'd1) >> LANE_W);
    end

    // Input word decode.
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign act        = t_action'(i_in.action);
    assign k_ok       = 32'(i_in.depth_index) < 32'(depth_eff);
    assign n_ok       = 32'(i_in.column_index) < 32'(cols_eff);
    assign in_lane    = i_in.column_index[LANE_W-1:0];
    assign in_grp     = GRP_W'(32'(i_in.column_index) >> LANE_W);
    assign mac_issue  = (r_state == S_MAC);

    // Store addresses: the sweep owns them while it runs.
    always_comb begin
        if (mac_issue) begin
            wt_addr  = WA_W'(32'(r_k) * GROUPS + 32'(r_grp));
            grp_addr = r_grp;
        end else begin
            wt_addr  = WA_W'(32'(i_in.depth_index) * GROUPS + 32'(in_grp));
            grp_addr = in_grp;
        end
    end

    // Lanes.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign lane_ctl[l].wt_we   = in_acc && (act == ACT_WR_WEIGHT) && k_ok && n_ok
                                     && (in_lane == LANE_W'(l));
        assign lane_ctl[l].bias_we = in_acc && (act == ACT_WR_BIAS) && n_ok
                                     && (in_lane == LANE_W'(l));
        assign lane_ctl[l].rd_en   = mac_issue || (in_acc && (act == ACT_READ));
        assign lane_ctl[l].mac_en  = mac_issue;
        assign lane_ctl[l].col_use = (32'(r_grp) * LANES + l) < 32'(cols_eff);
        assign lane_ctl[l].first_k = (r_k == '0);

        gemm_lane #(
            .GROUPS    (GROUPS),
            .WT_DEPTH  (WT_DEPTH),
            .ACC_WIDTH (ACC_WIDTH)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (lane_ctl[l]),
            .i_wt_addr   (wt_addr),
            .i_grp       (grp_addr),
            .i_wt_data   (i_in.weight_value),
            .i_bias_data (i_in.bias_value),
            .i_act       (r_act),
            .o_acc       (lane_acc[l])
        );
    end

    // Clamp the selected accumulator to 0..65535; the top bit is the sign.
    always_comb begin
        acc_sel = lane_acc[r_lane];
        if (acc_sel[ACC_WIDTH-1]) begin
            clamped = '0;
        end else if (acc_sel[ACC_WIDTH-2:RES_W] != '0) begin
            clamped = RES_MAX;
        end else begin
            clamped = acc_sel[RES_W-1:0];
        end
        col_last = (32'(r_col) == (32'(cols_eff) - 32'd1));
        row_wrap = ((17'(r_row) + 17'd1) >= 17'(rows_eff));
    end

    // Sequencer, row tracking and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_grp     <= '0;
            r_drain   <= 1'b0;
            r_row     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // A taken result frees the register unless the read state refills it now.
            if (o_res.valid && o_res.ready && (r_state != S_RDOUT)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (act) inside
                            ACT_ELEMENT: begin
                                if (k_ok) begin
                                    r_k     <= i_in.depth_index;
                                    r_act   <= i_in.act_value;
                                    r_grp   <= '0;
                                    r_state <= S_MAC;
                                end
                            end
                            ACT_READ: begin
                                if (n_ok) begin
                                    r_lane  <= in_lane;
                                    r_col   <= i_in.column_index;
                                    r_state <= S_RDOUT;
                                end
                            end
                            ACT_WR_WEIGHT, ACT_WR_BIAS: ;
                        endcase
                    end
                end
                S_MAC: begin
                    if (r_grp == last_grp) begin
                        r_drain <= 1'b0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_grp <= r_grp + GRP_W'(1);
                    end
                end
                S_DRAIN: begin
                    // Wait for the last group to reach the accumulator bank.
                    if (r_drain) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_drain <= 1'b1;
                    end
                end
                S_RDOUT: begin
                    if (!r_out_vld || o_res.ready) begin
                        r_out_vld  <= 1'b1;
                        r_out_val  <= clamped;
                        r_out_col  <= r_col;
                        r_out_last <= col_last && row_wrap;
                        if (col_last) begin
                            r_row <= row_wrap ? '0 : (r_row + ROWS_W'(1));
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.result_value   = r_out_val;
    assign o_res.result_column  = r_out_col;
    assign o_res.last_of_matrix = r_out_last;

    // An accepted in-range element always starts a sweep.
    a_elem_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (act == ACT_ELEMENT) && k_ok |=> (r_state == S_MAC))
        else $error("element did not start a sweep");

    // The sweep never runs past the last group in use.
    a_grp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_grp <= last_grp))
        else $error("sweep group out of range");

    // A new result is loaded only from the read state.
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_RDOUT))
        else $error("result without a read");

    // The end-of-matrix flag only comes with the last column in use.
    a_last_on_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.last_of_matrix
            |-> (32'(o_res.result_column) == (32'(cols_eff) - 32'd1)))
        else $error("last flag on a column that is not last");

endmodule
